// ===== rtl/core/alrg_pkg.sv =====
`default_nettype none

package alrg_pkg;

  // Table geometry
  localparam int unsigned TableDepth = 33;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned WordW      = 32;
  localparam int unsigned ExtW       = 8;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [WordW-1:0] word_t;
  typedef logic [ExtW-1:0]  ext_t;

  // Request opcodes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  // Seeding chain and lag constants
  localparam word_t DefaultSeed = 32'd34057;
  localparam word_t LcgMul      = 32'h46A2E297;
  localparam word_t LcgAdd      = 32'h00EF353B;
  localparam idx_t  SeedPointer = idx_t'(15 % TableDepth);
  localparam idx_t  BaseLag     = idx_t'(9);
  localparam idx_t  ExtLagBase  = idx_t'(6);
  localparam idx_t  LastIdx     = idx_t'(TableDepth - 1);

  // (ext * 59) mod 9 == (5 * (ext mod 9)) mod 9; ext mod 9 by folding,
  // since 64 and 8 are +1 and -1 modulo 9.
  function automatic logic [3:0] ext_lag(input ext_t ext);
    logic [6:0] fold;
    logic [4:0] diff;
    logic [3:0] rem;
    logic [3:0] lag;
    fold = {5'b0, ext[7:6]} + {1'b0, ext[5:0]};
    diff = {2'b0, fold[2:0]} + 5'd9 - {1'b0, fold[6:3]};
    if (diff >= 5'd9) begin
      rem = 4'(diff - 5'd9);
    end else begin
      rem = diff[3:0];
    end
    case (rem)
      4'd0:    lag = 4'd0;
      4'd1:    lag = 4'd5;
      4'd2:    lag = 4'd1;
      4'd3:    lag = 4'd6;
      4'd4:    lag = 4'd2;
      4'd5:    lag = 4'd7;
      4'd6:    lag = 4'd3;
      4'd7:    lag = 4'd8;
      4'd8:    lag = 4'd4;
      default: lag = 4'd0;
    endcase
    return lag;
  endfunction

  // Partner entry for the word at ptr, wrapped into the table
  function automatic idx_t partner_idx(input idx_t ptr, input logic ext_mode,
                                       input ext_t ext);
    logic [IdxW:0] sum;
    sum = {1'b0, ptr};
    if (ext_mode) begin
      sum = sum + {1'b0, ExtLagBase} + (IdxW+1)'(ext_lag(ext));
    end else begin
      sum = sum + {1'b0, BaseLag};
    end
    if (sum >= (IdxW+1)'(TableDepth)) begin
      sum = sum - (IdxW+1)'(TableDepth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/alrg_if.sv =====
`default_nettype none

// Request channel: one draw or reseed command
interface alrg_req_if;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  alrg_pkg::word_t      seed_value;
  logic                 use_ext;
  alrg_pkg::ext_t       ext_byte;

  modport source (output valid, output opcode, output seed_value, output use_ext,
                  output ext_byte, input ready);
  modport sink   (input valid, input opcode, input seed_value, input use_ext,
                  input ext_byte, output ready);
endinterface

// Result channel: one random word per draw
interface alrg_rsp_if;
  logic                 valid;
  logic                 ready;
  alrg_pkg::word_t      random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/additive_lagged_random_generator.sv =====
`default_nettype none

// Additive lagged random generator over a 33-word table.
// Requests come in on req_i (valid/ready); opcode selects a draw or a
// reseed. A reseed writes the 33-entry table from a multiply-add chain,
// one entry per cycle through a single 32x32 multiplier, and returns
// nothing. A draw returns one word on rsp_o.
// A draw on a seeded table reads the pointer entry and its partner from
// the table's two read ports when it is accepted, then writes the sum
// back and loads the result register once the result register is free.
// A draw before any reseed first runs the fill with the default seed.
// req_i.ready is high only while the sequencer is idle. The result sits
// in an output register; a request may be taken while it waits, but a
// following draw holds in its write-back step until the receiver takes
// the earlier result, so nothing is lost when rsp_o stalls.
// Reset clears pointer, seeded and mode flags and the result valid; the
// table contents are undefined until the first reseed fills them.
module additive_lagged_random_generator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  alrg_req_if.sink    req_i,
  alrg_rsp_if.source  rsp_o
);
  import alrg_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSeed = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StWrite = 2'd3;

  logic [1:0] state_q, state_d;
  idx_t       ptr_q, ptr_d;
  idx_t       fill_idx_q, fill_idx_d;
  word_t      chain_q, chain_d;
  logic       seeded_q, seeded_d;
  logic       ext_mode_q, ext_mode_d;
  logic       draw_after_q, draw_after_d;
  logic       out_valid_q, out_valid_d;
  word_t      out_word_q, out_word_d;

  word_t      lag_table [TableDepth];
  word_t      rd_a_q, rd_b_q;
  logic       tbl_we, tbl_re;
  idx_t       tbl_waddr, rd_b_addr;
  word_t      tbl_wdata;
  word_t      chain_prod;
  word_t      draw_sum;
  logic       req_fire, out_free;

  assign req_i.ready       = (state_q == StIdle);
  assign req_fire          = req_i.valid && req_i.ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.random_word = out_word_q;
  assign out_free          = !out_valid_q || rsp_o.ready;

  // datapath: chain multiplier and draw adder
  assign chain_prod = chain_q * LcgMul;
  assign draw_sum   = rd_a_q + rd_b_q;
  assign rd_b_addr  = partner_idx(ptr_q, ext_mode_q, req_i.ext_byte);

  // sequencer
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    fill_idx_d   = fill_idx_q;
    chain_d      = chain_q;
    seeded_d     = seeded_q;
    ext_mode_d   = ext_mode_q;
    draw_after_d = draw_after_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_word_d   = out_word_q;
    tbl_we       = 1'b0;
    tbl_re       = 1'b0;
    tbl_waddr    = fill_idx_q;
    tbl_wdata    = chain_q;
    case (state_q)
      StIdle: begin
        if (req_fire) begin
          if (req_i.opcode == OP_SEED || !seeded_q) begin
            state_d      = StSeed;
            fill_idx_d   = '0;
            seeded_d     = 1'b1;
            ptr_d        = SeedPointer;
            draw_after_d = (req_i.opcode == OP_DRAW);
            if (req_i.opcode == OP_SEED) begin
              chain_d    = req_i.seed_value;
              ext_mode_d = req_i.use_ext;
            end else begin
              chain_d    = DefaultSeed;
              ext_mode_d = 1'b0;
            end
          end else begin
            tbl_re  = 1'b1;
            state_d = StWrite;
          end
        end
      end
      StSeed: begin
        tbl_we     = 1'b1;
        chain_d    = chain_prod + LcgAdd;
        fill_idx_d = fill_idx_q + idx_t'(1);
        if (fill_idx_q == LastIdx) begin
          state_d = draw_after_q ? StRead : StIdle;
        end
      end
      StRead: begin
        // only reached after a default seed, so the external byte is unused
        tbl_re  = 1'b1;
        state_d = StWrite;
      end
      StWrite: begin
        if (out_free) begin
          tbl_we      = 1'b1;
          tbl_waddr   = ptr_q;
          tbl_wdata   = draw_sum;
          out_valid_d = 1'b1;
          out_word_d  = draw_sum;
          ptr_d       = (ptr_q == LastIdx) ? '0 : ptr_q + idx_t'(1);
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // table memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      lag_table[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      rd_a_q <= lag_table[ptr_q];
      rd_b_q <= lag_table[rd_b_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ptr_q        <= '0;
      fill_idx_q   <= '0;
      seeded_q     <= 1'b0;
      ext_mode_q   <= 1'b0;
      draw_after_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      fill_idx_q   <= fill_idx_d;
      seeded_q     <= seeded_d;
      ext_mode_q   <= ext_mode_d;
      draw_after_q <= draw_after_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    chain_q    <= chain_d;
    out_word_q <= out_word_d;
  end

endmodule

`default_nettype wire

// ===== dv/tb_additive_lagged_random_generator.sv =====
`timescale 1ns / 1ps

module tb_additive_lagged_random_generator;
  import alrg_pkg::*;

  localparam int unsigned ClkPeriod     = 4;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned IdlePct       = 9;
  localparam int unsigned RandomReqs    = 400;
  localparam int unsigned SeedPct       = 8;
  localparam int unsigned HoldAfter     = 120;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned CalmLo        = 200;
  localparam int unsigned CalmHi        = 290;
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned WatchdogLimit = 3000;

  // Partner lag rules of the generator
  localparam int unsigned DrawLag     = 9;
  localparam int unsigned PerturbBase = 6;
  localparam int unsigned PerturbMul  = 59;
  localparam int unsigned PerturbMod  = 9;

  typedef struct {
    logic  opcode;
    word_t seed;
    logic  use_ext;
    ext_t  ext;
    bit    drain;  // sender waits for all outstanding words before offering
  } gen_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  alrg_req_if req_if ();
  alrg_rsp_if rsp_if ();

  additive_lagged_random_generator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  gen_req_t    req_queue[$];
  gen_req_t    cur_req;
  word_t       expected_words[$];
  word_t       want_word;
  int unsigned sent_cnt;
  int unsigned words_checked;
  int unsigned mismatch_cnt;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned quiet_cycles;

  // Shadow copy of the generator state
  word_t       gen_table[TableDepth];
  int unsigned gen_ptr;
  bit          gen_seeded;
  bit          gen_ext_mode;

  // Fill the table with the multiply-add chain starting at the seed
  function automatic void predict_fill(word_t seed, bit ext_mode);
    gen_seeded   = 1'b1;
    gen_ext_mode = ext_mode;
    gen_ptr      = int'(SeedPointer);
    gen_table[0] = seed;
    for (int k = 1; k < TableDepth; k++) begin
      gen_table[k] = LcgMul * gen_table[k-1] + LcgAdd;
    end
  endfunction

  // One draw: add partner entry into pointer entry, advance pointer
  function automatic word_t predict_draw(ext_t ext);
    int unsigned partner;
    word_t       word;
    if (!gen_seeded) begin
      predict_fill(DefaultSeed, 1'b0);
    end
    if (gen_ext_mode) begin
      partner = gen_ptr + PerturbBase + ((32'(ext) * PerturbMul) % PerturbMod);
    end else begin
      partner = gen_ptr + DrawLag;
    end
    partner = partner % TableDepth;
    word = gen_table[gen_ptr] + gen_table[partner];
    gen_table[gen_ptr] = word;
    gen_ptr = (gen_ptr + 1) % TableDepth;
    return word;
  endfunction

  function automatic void add_req(logic opcode, word_t seed, logic use_ext, ext_t ext,
                                  bit drain);
    gen_req_t r;
    r.opcode  = opcode;
    r.seed    = seed;
    r.use_ext = use_ext;
    r.ext     = ext;
    r.drain   = drain;
    req_queue.push_back(r);
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.opcode     <= OP_DRAW;
      req_if.seed_value <= '0;
      req_if.use_ext    <= 1'b0;
      req_if.ext_byte   <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (cur_req.opcode == OP_SEED) begin
          predict_fill(cur_req.seed, cur_req.use_ext);
        end else begin
          expected_words.push_back(predict_draw(cur_req.ext));
        end
        sent_cnt++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_queue.size() != 0
            && !(req_queue[0].drain && expected_words.size() != 0)
            && ((sent_cnt >= CalmLo && sent_cnt < CalmHi)
                || $urandom_range(99) >= IdlePct)) begin
          cur_req = req_queue.pop_front();
          req_if.valid      <= 1'b1;
          req_if.opcode     <= cur_req.opcode;
          req_if.seed_value <= cur_req.seed;
          req_if.use_ext    <= cur_req.use_ext;
          req_if.ext_byte   <= cur_req.ext;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: random_word expected none, actual %08h", $time,
                   rsp_if.random_word);
          mismatch_cnt++;
        end else begin
          want_word = expected_words.pop_front();
          if (rsp_if.random_word !== want_word) begin
            $display("%0t: random_word expected %08h, actual %08h", $time,
                     want_word, rsp_if.random_word);
            mismatch_cnt++;
          end
        end
        words_checked++;
      end
      // one long hold-off so the block backs up into the request side
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && words_checked >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= (words_checked >= CalmLo && words_checked < CalmHi)
                        || $urandom_range(99) >= IdlePct;
      end
    end
  end

  // Watchdog on handshake inactivity
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    gen_gen_init: begin
      word_t seed;
      logic  opcode;
      req_if.valid      = 1'b0;
      req_if.opcode     = OP_DRAW;
      req_if.seed_value = '0;
      req_if.use_ext    = 1'b0;
      req_if.ext_byte   = '0;
      rsp_if.ready      = 1'b0;
      rst_ni            = 1'b0;
      sent_cnt          = 0;
      words_checked     = 0;
      mismatch_cnt      = 0;
      hold_left         = 0;
      hold_done         = 1'b0;
      gen_ptr           = 0;
      gen_seeded        = 1'b0;
      gen_ext_mode      = 1'b0;

      // Directed: draws before any seed self-seed with the default value
      add_req(OP_DRAW, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0);
      add_req(OP_DRAW, 32'h0, 1'b0, 8'h00, 1'b0);
      // Reseed ignores the external byte
      add_req(OP_SEED, 32'h0, 1'b0, 8'hFF, 1'b0);
      add_req(OP_DRAW, 32'h0, 1'b0, 8'hFF, 1'b0);
      add_req(OP_DRAW, 32'h0, 1'b0, 8'h00, 1'b0);
      // Perturbed lag: bytes 0..8 hit every residue, plus the top byte
      add_req(OP_SEED, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b0);
      for (int e = 0; e <= 8; e++) begin
        add_req(OP_DRAW, 32'h0, 1'b0, ext_t'(e), 1'b0);
      end
      add_req(OP_DRAW, 32'h0, 1'b0, 8'hFF, 1'b0);
      add_req(OP_SEED, 32'h8000_0000, 1'b0, 8'hA5, 1'b0);
      add_req(OP_DRAW, 32'hFFFF_FFFF, 1'b1, 8'h5A, 1'b0);

      // Random: mostly draws with random bytes, occasional reseeds
      for (int i = 0; i < RandomReqs; i++) begin
        opcode = ($urandom_range(99) < SeedPct) ? OP_SEED : OP_DRAW;
        seed   = $urandom();
        add_req(opcode, seed, 1'($urandom_range(1)), ext_t'($urandom_range(255)),
                i == 0 || i == 250);
      end

      repeat (ResetCycles) @(posedge clk_i);
      rst_ni <= 1'b1;

      while (req_queue.size() != 0 || req_if.valid) @(posedge clk_i);
      while (expected_words.size() != 0) @(posedge clk_i);
      repeat (TailCycles) @(posedge clk_i);

      if (mismatch_cnt == 0 && expected_words.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/alrg_pkg.sv
rtl/core/alrg_if.sv
rtl/core/additive_lagged_random_generator.sv
dv/tb_additive_lagged_random_generator.sv
